>>> src/utf8_stream_decoder_assert.svh
// Assertion macros for the UTF-8 stream decoder.
// Used by the queue and back-end modules; no other dependencies.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define UTF8D_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("utf8d: check failed");

// Consequent must hold in the same cycle as the antecedent.
`define UTF8D_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("utf8d: check failed");

// Consequent must hold in the cycle after the antecedent.
`define UTF8D_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("utf8d: check failed");

`endif

>>> src/utf8d_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package utf8d_pkg;

   localparam int CP_W                = 21;
   localparam int BYTE_W              = 8;
   localparam int TRAIL_BITS          = 6;
   localparam int DEFAULT_QUEUE_DEPTH = 2;

   localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
   localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
   localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;
   localparam logic [BYTE_W-1:0] TRAIL_MASK = 8'h3F;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_LEAD  = 3'd1,
      ST_BAD_TRAIL = 3'd2,
      ST_TRUNC     = 3'd3,
      ST_NUL       = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CLS_NUL,
      CLS_ASCII,
      CLS_LEAD2,
      CLS_LEAD3,
      CLS_LEAD4,
      CLS_TRAIL,
      CLS_BAD
   } byte_cls_type;

   typedef struct packed {
      byte_cls_type      cls;
      logic [BYTE_W-1:0] data;
      logic              eoi;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

endpackage

`default_nettype wire

>>> src/utf8d_if.sv
// Valid/ready channel interfaces for byte requests and decoded responses.
// Depends on utf8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface utf8d_req_if;
   logic                         valid;
   logic                         ready;
   logic [utf8d_pkg::BYTE_W-1:0] in_byte;
   logic                         end_of_input;

   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface utf8d_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [utf8d_pkg::CP_W-1:0] code_point;
   logic [2:0]                 status;
   logic                       final_result;

   modport source (output valid, output code_point, output status, output final_result,
                   input ready);
   modport sink   (input valid, input code_point, input status, input final_result,
                   output ready);
endinterface

`default_nettype wire

>>> src/utf8d_front.sv
// Front end: takes request transfers, classifies each byte and registers it.
// Depends on utf8d_pkg and utf8d_if.
`timescale 1ns / 1ps
`default_nettype none

module utf8d_front (
   input  wire logic               clock,
   input  wire logic               reset,
   utf8d_req_if.sink               req,
   output utf8d_pkg::item_type     push_item,
   output logic                    push_valid,
   input  wire logic               push_ready
);
   import utf8d_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   item_type item_in;
   logic     take;
   byte_cls_type cls;

   always_comb begin
      case (req.in_byte) inside
         8'h00:           cls = CLS_NUL;
         [8'h01:8'h7F]:   cls = CLS_ASCII;
         [8'h80:8'hBF]:   cls = CLS_TRAIL;
         [8'hC0:8'hDF]:   cls = CLS_LEAD2;
         [8'hE0:8'hEF]:   cls = CLS_LEAD3;
         [8'hF0:8'hF7]:   cls = CLS_LEAD4;
         default:         cls = CLS_BAD;
      endcase
   end

   assign req.ready = !valid_ff || push_ready;
   assign take      = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in     = 1'b1;
         item_in.cls  = cls;
         item_in.data = req.in_byte;
         item_in.eoi  = req.end_of_input;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule

`default_nettype wire

>>> src/utf8d_queue.sv
// Short queue of classified bytes between the front and back ends.
// Depends on utf8d_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_stream_decoder_assert.svh"

module utf8d_queue #(
   parameter int DEPTH = utf8d_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   input  wire utf8d_pkg::item_type push_item,
   output logic                     push_ready,
   output utf8d_pkg::head_type      head,
   input  wire logic                pop
);
   import utf8d_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             push_fire;

   assign push_ready = (cnt_ff != CNT_W'(DEPTH));
   assign push_fire  = push_valid && push_ready;
   assign head.valid = (cnt_ff != '0);
   assign head.item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_fire && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push_fire) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push_fire) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   `UTF8D_ASSERT_ALWAYS(a_cnt_bound, clock, reset, cnt_ff <= CNT_W'(DEPTH))
   `UTF8D_ASSERT_IMPLY(a_pop_nonempty, clock, reset, pop, cnt_ff != '0)
   `UTF8D_ASSERT_NEXT(a_push_grows, clock, reset, push_fire && !pop, cnt_ff == $past(cnt_ff) + 1)

endmodule

`default_nettype wire

>>> src/utf8d_back.sv
// Back end: runs the decode state machine and holds the response register.
// Depends on utf8d_pkg, utf8d_if and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_stream_decoder_assert.svh"

module utf8d_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire utf8d_pkg::head_type head,
   output logic                     pop,
   utf8d_rsp_if.source              rsp
);
   import utf8d_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_NEED1 = 4'b0010,
      S_NEED2 = 4'b0100,
      S_NEED3 = 4'b1000
   } dec_state_type;

   dec_state_type     state_ff;
   dec_state_type     state_in;
   logic [CP_W-1:0]   partial_ff;
   logic [CP_W-1:0]   partial_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [CP_W-1:0]   cp_ff;
   status_type        status_ff;
   logic              final_ff;
   logic              emit;
   logic              lead_seen;
   logic [CP_W-1:0]   res_cp;
   status_type        res_st;
   logic [CP_W-1:0]   trail6;
   item_type          item;

   assign item   = head.item;
   assign pop    = head.valid && (!rsp_valid_ff || rsp.ready);
   assign trail6 = CP_W'(item.data & TRAIL_MASK);

   always_comb begin
      state_in   = state_ff;
      partial_in = partial_ff;
      emit       = 1'b0;
      lead_seen  = 1'b0;
      res_cp     = '0;
      res_st     = ST_OK;
      case (state_ff)
         S_IDLE: begin
            case (item.cls)
               CLS_NUL: begin
                  emit   = 1'b1;
                  res_st = ST_NUL;
               end
               CLS_ASCII: begin
                  emit   = 1'b1;
                  res_cp = CP_W'(item.data);
               end
               CLS_LEAD2: begin
                  lead_seen  = 1'b1;
                  state_in   = S_NEED1;
                  partial_in = CP_W'(item.data & LEAD2_MASK) << TRAIL_BITS;
               end
               CLS_LEAD3: begin
                  lead_seen  = 1'b1;
                  state_in   = S_NEED2;
                  partial_in = CP_W'(item.data & LEAD3_MASK) << (2 * TRAIL_BITS);
               end
               CLS_LEAD4: begin
                  lead_seen  = 1'b1;
                  state_in   = S_NEED3;
                  partial_in = CP_W'(item.data & LEAD4_MASK) << (3 * TRAIL_BITS);
               end
               default: begin
                  emit   = 1'b1;
                  res_st = ST_BAD_LEAD;
               end
            endcase
         end
         S_NEED1: begin
            emit       = 1'b1;
            state_in   = S_IDLE;
            partial_in = '0;
            if (item.cls == CLS_TRAIL) begin
               res_cp = partial_ff | trail6;
            end else begin
               res_st = ST_BAD_TRAIL;
            end
         end
         S_NEED2: begin
            lead_seen  = 1'b1;
            state_in   = S_NEED1;
            partial_in = partial_ff | (trail6 << TRAIL_BITS);
         end
         S_NEED3: begin
            lead_seen  = 1'b1;
            state_in   = S_NEED2;
            partial_in = partial_ff | (trail6 << (2 * TRAIL_BITS));
         end
         default: begin
            state_in   = S_IDLE;
            partial_in = '0;
         end
      endcase
      // drop a broken sequence as a bad trail; flag an unfinished one at end of input
      if (lead_seen && state_ff != S_IDLE && item.cls != CLS_TRAIL) begin
         emit       = 1'b1;
         res_st     = ST_BAD_TRAIL;
         state_in   = S_IDLE;
         partial_in = '0;
      end else if (lead_seen && item.eoi) begin
         emit       = 1'b1;
         res_st     = ST_TRUNC;
         state_in   = S_IDLE;
         partial_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = emit;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         partial_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            state_ff   <= state_in;
            partial_ff <= partial_in;
         end
      end
      if (pop && emit) begin
         cp_ff     <= res_cp;
         status_ff <= res_st;
         final_ff  <= item.eoi;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.code_point   = cp_ff;
   assign rsp.status       = status_ff;
   assign rsp.final_result = final_ff;

   `UTF8D_ASSERT_IMPLY(a_err_zero_cp, clock, reset, rsp_valid_ff && status_ff != ST_OK, cp_ff == '0)
   `UTF8D_ASSERT_NEXT(a_eoi_idle, clock, reset, pop && item.eoi, state_ff == S_IDLE)
   `UTF8D_ASSERT_NEXT(a_eoi_result, clock, reset, pop && item.eoi, rsp_valid_ff && final_ff)

endmodule

`default_nettype wire

>>> src/utf8_stream_decoder.sv
// Streaming UTF-8 decoder, one byte per request transfer, at most one response per byte.
// A final byte passes the front register, the queue and the response register.
// Throughput: one byte per cycle unless stalled; the queue lets each end stall alone.
// Reset (synchronous, active high) empties the front stage and queue and returns
// the decoder to idle with no response pending.
// Depends on utf8d_pkg, utf8d_if, utf8d_front, utf8d_queue and utf8d_back.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder #(
   parameter int QUEUE_DEPTH = utf8d_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  wire logic   clock,
   input  wire logic   reset,
   utf8d_req_if.sink   req_chan,
   utf8d_rsp_if.source rsp_chan
);
   import utf8d_pkg::*;

   item_type push_item;
   logic     push_valid;
   logic     push_ready;
   head_type head;
   logic     pop;

   utf8d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .push_item  (push_item),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   utf8d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .head       (head),
      .pop        (pop)
   );

   utf8d_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

endmodule

`default_nettype wire
